@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define AST_HOLDS(lbl, clk, rst_n, cond, msg)
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/wsht_pkg.sv @@
package wsht_pkg;

	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int NUM_W    = 5;
	localparam int OUT_W    = ((NUM_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_CLICK = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_HIT     = 2'd1,
		STAT_IGNORED = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

endpackage

@@ src/window_stack_hit_test.sv @@
// Window stack hit test. Keeps up to MAX_WINDOWS rectangles stacked front to back and takes one
// command per input beat (tuser): clear, add a window on top, or click at a point. Every command
// gives exactly one output beat: status in tuser, the 1-based number of the window hit in tdata.
// A click walks the stack from the top through a single rectangle compare unit, one window per
// cycle behind a two-stage memory read (order list, then rectangle), and on a hit rotates the
// order list one entry per cycle to bring that window to the top; an add puts its new window
// on top through the same rotation, and a clear only resets the window count.
// The input is not ready while a command is in progress; the output register lets the next
// command start while the previous result waits. No clearing pass is needed after reset.
module window_stack_hit_test #(
	parameter int MAX_WINDOWS = 16,
	parameter int COORD_BITS  = 12,
	localparam int IN_W = ((6 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// left, bottom, right, top, point_x, point_y; zero padded
	input  logic [IN_W-1:0]               s_tdata,
	// command
	input  logic [wsht_pkg::CMD_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// window_number; zero padded
	output logic [wsht_pkg::OUT_W-1:0]    m_tdata,
	// status
	output logic [wsht_pkg::STATUS_W-1:0] m_tuser
);

	import wsht_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
	localparam int RECT_W = 4 * COORD_BITS;
	localparam int SUM_W  = (IDX_W + 1 > NUM_W) ? IDX_W + 1 : NUM_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       j_q;
	logic [IDX_W-1:0]       k_q;
	logic [IDX_W-1:0]       w_q;
	logic [COORD_BITS-1:0]  px_q;
	logic [COORD_BITS-1:0]  py_q;
	status_t                res_status_q;
	logic [NUM_W-1:0]       res_num_q;

	// scan pipeline: order read, then rectangle read
	logic                   v_s1;
	logic [IDX_W-1:0]       j_s1;
	logic                   v_s2;
	logic [IDX_W-1:0]       j_s2;
	logic [IDX_W-1:0]       w_s2;

	// rotation: one read in flight
	logic                   sh_v_s1;
	logic [IDX_W-1:0]       sh_k_s1;

	logic                   m_tvalid_q;
	status_t                m_status_q;
	logic [NUM_W-1:0]       m_num_q;

	// memories and their read registers
	logic [RECT_W-1:0]      rect_mem [MAX_WINDOWS];
	logic [IDX_W-1:0]       ord_mem  [MAX_WINDOWS];
	logic [RECT_W-1:0]      rect_rd_q;
	logic [IDX_W-1:0]       ord_rd_q;

	logic                   accept;
	logic                   rect_we;
	logic                   ord_we;
	logic [IDX_W-1:0]       ord_waddr;
	logic [IDX_W-1:0]       ord_wdata;
	logic [IDX_W-1:0]       ord_raddr;
	logic                   hit;
	logic [SUM_W-1:0]       num_sum;
	logic [COORD_BITS-1:0]  r_left;
	logic [COORD_BITS-1:0]  r_bottom;
	logic [COORD_BITS-1:0]  r_right;
	logic [COORD_BITS-1:0]  r_top;
	logic                   out_free;
	cmd_t                   cmd;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{(OUT_W - NUM_W){1'b0}}, m_num_q};

	// compare unit: point against the rectangle read for stage two
	assign r_left   = rect_rd_q[COORD_BITS-1:0];
	assign r_bottom = rect_rd_q[2*COORD_BITS-1:COORD_BITS];
	assign r_right  = rect_rd_q[3*COORD_BITS-1:2*COORD_BITS];
	assign r_top    = rect_rd_q[4*COORD_BITS-1:3*COORD_BITS];
	assign hit      = (r_left <= px_q) && (px_q <= r_right) &&
	                  (r_bottom <= py_q) && (py_q <= r_top);

	assign num_sum  = SUM_W'(w_s2) + SUM_W'(1);

	// store a new rectangle when an add finds room
	assign rect_we = accept && (cmd == CMD_ADD) && (cnt_q < CNT_W'(MAX_WINDOWS));

	// order list ports: scan reads upward, rotation reads downward
	always_comb begin
		ord_raddr = j_q[IDX_W-1:0];
		if (state_q == S_SHIFT) begin
			ord_raddr = k_q - IDX_W'(1);
		end
		ord_we    = (state_q == S_SHIFT) && (sh_v_s1 || (k_q == '0));
		ord_waddr = sh_v_s1 ? sh_k_s1 : '0;
		ord_wdata = sh_v_s1 ? ord_rd_q : w_q;
	end

	always_ff @(posedge clk) begin
		if (rect_we) begin
			rect_mem[cnt_q[IDX_W-1:0]] <= s_tdata[RECT_W-1:0];
		end
		rect_rd_q <= rect_mem[ord_rd_q];
	end

	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		ord_rd_q <= ord_mem[ord_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			j_q          <= '0;
			k_q          <= '0;
			w_q          <= '0;
			px_q         <= '0;
			py_q         <= '0;
			res_status_q <= STAT_DONE;
			res_num_q    <= '0;
			v_s1         <= 1'b0;
			j_s1         <= '0;
			v_s2         <= 1'b0;
			j_s2         <= '0;
			w_s2         <= '0;
			sh_v_s1      <= 1'b0;
			sh_k_s1      <= '0;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= STAT_DONE;
			m_num_q      <= '0;
		end else begin
			// drop the output beat once taken
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= STAT_DONE;
						res_num_q    <= '0;
						state_q      <= S_OUT;
						case (cmd)
							CMD_CLEAR: begin
								cnt_q <= '0;
							end
							CMD_ADD: begin
								if (cnt_q < CNT_W'(MAX_WINDOWS)) begin
									w_q     <= cnt_q[IDX_W-1:0];
									k_q     <= cnt_q[IDX_W-1:0];
									cnt_q   <= cnt_q + CNT_W'(1);
									state_q <= S_SHIFT;
								end else begin
									res_status_q <= STAT_FULL;
								end
							end
							CMD_CLICK: begin
								px_q         <= s_tdata[5*COORD_BITS-1:4*COORD_BITS];
								py_q         <= s_tdata[6*COORD_BITS-1:5*COORD_BITS];
								j_q          <= '0;
								res_status_q <= STAT_IGNORED;
								state_q      <= S_SCAN;
							end
							default: begin
								res_status_q <= STAT_DONE;
							end
						endcase
					end
				end

				S_SCAN: begin
					// advance the read pipeline
					v_s1 <= (j_q < cnt_q);
					j_s1 <= j_q[IDX_W-1:0];
					if (j_q < cnt_q) begin
						j_q <= j_q + CNT_W'(1);
					end
					v_s2 <= v_s1;
					j_s2 <= j_s1;
					w_s2 <= ord_rd_q;
					if (v_s2 && hit) begin
						// first hit from the top: flush and rotate it to the front
						v_s1         <= 1'b0;
						v_s2         <= 1'b0;
						w_q          <= w_s2;
						k_q          <= j_s2;
						res_status_q <= STAT_HIT;
						res_num_q    <= num_sum[NUM_W-1:0];
						state_q      <= S_SHIFT;
					end else if ((j_q >= cnt_q) && !v_s1) begin
						v_s2    <= 1'b0;
						state_q <= S_OUT;
					end
				end

				S_SHIFT: begin
					// move entries down by one, then write the front entry
					if (k_q != '0) begin
						sh_v_s1 <= 1'b1;
						sh_k_s1 <= k_q;
						k_q     <= k_q - IDX_W'(1);
					end else begin
						sh_v_s1 <= 1'b0;
						if (!sh_v_s1) begin
							state_q <= S_OUT;
						end
					end
				end

				S_OUT: begin
					// hold the result until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_num_q    <= res_num_q;
						state_q    <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`AST_HOLDS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(MAX_WINDOWS), "window count overflow")
	`AST_IMPLIES(a_scan_in_range, clk, arst_n, v_s2, CNT_W'(j_s2) < cnt_q, "scan beyond stack")
	`AST_IMPLIES(a_shift_no_top, clk, arst_n, sh_v_s1, sh_k_s1 != '0, "shift wrote the top entry")
	`AST_IMPLIES(a_moved_exists, clk, arst_n, state_q == S_SHIFT, CNT_W'(w_q) < cnt_q, "bad window")
	`AST_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready after accept")

endmodule

@@ bench/tb_window_stack_hit_test.sv @@
module tb_window_stack_hit_test;
	import wsht_pkg::*;

	localparam int WIN_MAX      = 16;
	localparam int XY_W         = 12;
	localparam int DATA_W       = 6 * XY_W;
	localparam int RANDOM_ITEMS = 1825;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_GAP      = 13;

	typedef logic [XY_W-1:0] coord_t;

	typedef struct packed {
		status_t           status;
		logic [NUM_W-1:0]  number;
	} outcome_t;

	// Mirror of the window stack; predicts one outcome per accepted command
	class window_scoreboard;
		coord_t      win_left[WIN_MAX];
		coord_t      win_bottom[WIN_MAX];
		coord_t      win_right[WIN_MAX];
		coord_t      win_top[WIN_MAX];
		int unsigned z_order[WIN_MAX];
		int unsigned win_count;
		outcome_t    outcome_q[$];
		int unsigned errors;
		int unsigned hits;
		int unsigned misses;
		int unsigned refusals;
		int unsigned results;

		function new();
			win_count = 0;
			errors    = 0;
			hits      = 0;
			misses    = 0;
			refusals  = 0;
			results   = 0;
		endfunction

		function bit covers(int unsigned w, coord_t x, coord_t y);
			return win_left[w] <= x && x <= win_right[w] &&
				win_bottom[w] <= y && y <= win_top[w];
		endfunction

		function void note_command(cmd_t cmd, coord_t l, coord_t b, coord_t r, coord_t t,
				coord_t x, coord_t y);
			outcome_t    o;
			int unsigned hit_pos;
			int unsigned w;
			bit          found;
			o.status = STAT_DONE;
			o.number = '0;
			found    = 1'b0;
			hit_pos  = 0;
			case (cmd)
				CMD_CLEAR: win_count = 0;
				CMD_ADD: begin
					if (win_count >= WIN_MAX) begin
						o.status = STAT_FULL;
					end else begin
						win_left[win_count]   = l;
						win_bottom[win_count] = b;
						win_right[win_count]  = r;
						win_top[win_count]    = t;
						for (int k = win_count; k > 0; k--)
							z_order[k] = z_order[k-1];
						z_order[0] = win_count;
						win_count++;
					end
				end
				CMD_CLICK: begin
					o.status = STAT_IGNORED;
					// scan front to back for the first window holding the point
					for (int unsigned j = 0; j < win_count && !found; j++) begin
						if (covers(z_order[j], x, y)) begin
							found   = 1'b1;
							hit_pos = j;
						end
					end
					// bring the hit window to the front
					if (found) begin
						w = z_order[hit_pos];
						for (int k = hit_pos; k > 0; k--)
							z_order[k] = z_order[k-1];
						z_order[0] = w;
						o.status = STAT_HIT;
						o.number = NUM_W'(w + 1);
					end
				end
				default: ;
			endcase
			outcome_q.push_back(o);
		endfunction

		function void check_result(status_t st, logic [NUM_W-1:0] num);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d number %0d",
					$time, st, num);
				return;
			end
			o = outcome_q.pop_front();
			results++;
			case (o.status)
				STAT_HIT:     hits++;
				STAT_IGNORED: misses++;
				STAT_FULL:    refusals++;
				default: ;
			endcase
			if (st !== o.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d actual %0d", $time, o.status, st);
			end
			if (num !== o.number) begin
				errors++;
				$display("%0t: window_number mismatch, expected %0d actual %0d",
					$time, o.number, num);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0]  s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	window_scoreboard sb = new();

	bit          tx_burst;
	bit          rx_burst;
	int unsigned rx_stall;
	int unsigned items_sent;
	int unsigned beats_out;
	int unsigned idle_cycles;

	window_stack_hit_test #(
		.MAX_WINDOWS (WIN_MAX),
		.COORD_BITS  (XY_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Drive the result ready: hold it low for the drawn stall after each beat
	initial begin
		m_tready = 1'b0;
		rx_stall = 0;
		rx_burst = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_stall > 0) begin
				m_tready = 1'b0;
				rx_stall--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Check every result beat and draw the next stall
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(status_t'(m_tuser), m_tdata[NUM_W-1:0]);
			beats_out++;
			if (beats_out % 50 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			rx_stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
		end
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Draw any coordinate
	function automatic coord_t any_xy();
		return coord_t'($urandom);
	endfunction

	// Send one command beat after a random gap; note it when accepted
	task automatic send_beat(cmd_t cmd, coord_t l, coord_t b, coord_t r, coord_t t,
			coord_t x, coord_t y);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {y, x, t, r, b, l};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, l, b, r, t, x, y);
		items_sent++;
	endtask

	// Draw a window: mostly modest overlapping boxes, some empty, some fully random
	task automatic random_window(output coord_t l, output coord_t b, output coord_t r,
			output coord_t t);
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			l = coord_t'($urandom_range(0, 3800));
			b = coord_t'($urandom_range(0, 3800));
			r = l + coord_t'($urandom_range(0, 295));
			t = b + coord_t'($urandom_range(0, 295));
		end else if (kind == 7) begin
			l = coord_t'($urandom_range(1, 4095));
			r = coord_t'($urandom_range(0, l - 1));
			b = any_xy();
			t = any_xy();
		end else begin
			l = any_xy();
			b = any_xy();
			r = any_xy();
			t = any_xy();
		end
	endtask

	// Pick a click point: mostly inside or on the edge of a stored window
	task automatic click_point(output coord_t x, output coord_t y);
		int unsigned mode;
		int unsigned w;
		mode = $urandom_range(0, 9);
		if (sb.win_count > 0 && mode < 8) begin
			w = $urandom_range(0, sb.win_count - 1);
			x = coord_t'($urandom_range(sb.win_right[w], sb.win_left[w]));
			y = coord_t'($urandom_range(sb.win_top[w], sb.win_bottom[w]));
			if (mode == 6) begin
				x = ($urandom_range(0, 1) != 0) ? sb.win_left[w] : sb.win_right[w];
				y = ($urandom_range(0, 1) != 0) ? sb.win_bottom[w] : sb.win_top[w];
			end else if (mode == 7) begin
				x = sb.win_right[w] + 1'b1;
			end
		end else begin
			x = any_xy();
			y = any_xy();
		end
	endtask

	initial begin
		coord_t      l, b, r, t, x, y;
		int unsigned pick;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = CMD_CLEAR;
		tx_burst    = 1'b0;
		items_sent  = 0;
		beats_out   = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty stack, unused command, full-screen and empty windows
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 100, 100);
		send_beat(CMD_NONE, any_xy(), any_xy(), any_xy(), any_xy(), any_xy(), any_xy());
		send_beat(CMD_ADD, 0, 0, 4095, 4095, any_xy(), any_xy());
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 0, 0);
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 4095, 4095);
		send_beat(CMD_ADD, 10, 0, 9, 4095, any_xy(), any_xy());
		send_beat(CMD_ADD, 0, 20, 4095, 19, any_xy(), any_xy());
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 10, 20);
		// Inclusive corners, then a click that raises the window underneath
		send_beat(CMD_ADD, 100, 200, 300, 400, any_xy(), any_xy());
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 100, 200);
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 300, 400);
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 301, 400);
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 200, 300);
		// Fill the table, overflow it, then clear
		while (sb.win_count < WIN_MAX) begin
			random_window(l, b, r, t);
			send_beat(CMD_ADD, l, b, r, t, any_xy(), any_xy());
		end
		send_beat(CMD_ADD, 5, 5, 50, 50, any_xy(), any_xy());
		send_beat(CMD_CLEAR, any_xy(), any_xy(), any_xy(), any_xy(), any_xy(), any_xy());
		send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), 2048, 2048);

		// Random mix weighted toward adds while the table has room
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0)
				tx_burst = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				while (sb.outcome_q.size() != 0) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				send_beat(CMD_CLEAR, any_xy(), any_xy(), any_xy(), any_xy(),
					any_xy(), any_xy());
			end else if (pick < 5) begin
				send_beat(CMD_NONE, any_xy(), any_xy(), any_xy(), any_xy(),
					any_xy(), any_xy());
			end else if (pick < 5 + ((sb.win_count < WIN_MAX) ? 40 : 8)) begin
				random_window(l, b, r, t);
				send_beat(CMD_ADD, l, b, r, t, any_xy(), any_xy());
			end else begin
				click_point(x, y);
				send_beat(CMD_CLICK, any_xy(), any_xy(), any_xy(), any_xy(), x, y);
			end
		end

		// Drain outstanding results, then watch for stray beats
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.outcome_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d commands; checked %0d results: %0d hits, %0d ignored clicks,",
			items_sent, sb.results, sb.hits, sb.misses);
		$display("%0d refused adds on a full table, %0d mismatches", sb.refusals, sb.errors);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
